// ----- rtl/smseq_pkg.sv -----
// Shared types and constants for the stepper motion sequencer.
`default_nettype none

package smseq_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_PAUSE = 3'd2;
    localparam logic [2:0] OP_HOME  = 3'd3;
    localparam logic [2:0] OP_SPEED = 3'd4;

    // Sequencer modes.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_IDLE   = 2'd0;
    localparam mode_t MODE_RUN    = 2'd1;
    localparam mode_t MODE_HOME   = 2'd2;
    localparam mode_t MODE_SETTLE = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_HOME_IVL = 1'b0;
    localparam logic REG_SETTLE   = 1'b1;

    // Register reset values.
    localparam logic [15:0] HOME_IVL_RESET = 16'd2500;
    localparam logic [31:0] SETTLE_RESET   = 32'd4000000;

    // Saturation limits of the homing and settling counters.
    localparam logic [15:0] HOME_ELAPSED_MAX   = 16'hFFFF;
    localparam logic [31:0] SETTLE_ELAPSED_MAX = 32'hFFFF_FFFF;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] home_step_interval;
        logic [31:0] settle_time;
    } cfg_t;

    // Status flags of one result.
    typedef struct packed {
        logic  step_pulse;
        logic  dir_level;
        mode_t mode;
        logic  reached_zero;
        logic  ready_res;
    } flags_t;

endpackage

`default_nettype wire

// ----- rtl/smseq_regs.sv -----
// Configuration registers of the stepper motion sequencer behind an APB-style port.
`default_nettype none

module smseq_regs
    import smseq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_step_interval <= HOME_IVL_RESET;
            cfg_reg.settle_time        <= SETTLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_HOME_IVL: cfg_reg.home_step_interval <= pwdata[15:0];
                REG_SETTLE:   cfg_reg.settle_time        <= pwdata;
                default:      ;
            endcase
        end
    end

    // Read data selection.
    always_comb
    begin
        unique case (paddr[2])
            REG_HOME_IVL: prdata = {16'd0, cfg_reg.home_step_interval};
            REG_SETTLE:   prdata = cfg_reg.settle_time;
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/smseq_core.sv -----
// Motion state and next-state logic of the stepper motion sequencer.
`default_nettype none

module smseq_core
    import smseq_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int INTERVAL_BITS = 24
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfg_t                     cfg,
    input  wire logic                     advance,
    input  wire logic [2:0]               operation,
    input  wire logic [INTERVAL_BITS-1:0] step_interval,
    input  wire logic                     direction,
    output flags_t                        flags,
    output logic [POSITION_BITS-1:0]      position
);

    mode_t                    mode_reg,       mode_next;
    logic [POSITION_BITS-1:0] step_count_reg, step_count_next;
    logic [INTERVAL_BITS-1:0] run_ivl_reg,    run_ivl_next;
    logic                     run_dir_reg,    run_dir_next;
    logic                     dir_pin_reg,    dir_pin_next;
    logic [INTERVAL_BITS-1:0] run_el_reg,     run_el_next;
    logic [15:0]              home_el_reg,    home_el_next;
    logic [31:0]              settle_el_reg,  settle_el_next;

    logic pulse, reached, ready;
    logic move_en, move_up;

    // Next state for one item.
    always_comb
    begin
        mode_next      = mode_reg;
        run_ivl_next   = run_ivl_reg;
        run_dir_next   = run_dir_reg;
        dir_pin_next   = dir_pin_reg;
        run_el_next    = run_el_reg;
        home_el_next   = home_el_reg;
        settle_el_next = settle_el_reg;
        pulse          = 1'b0;
        reached        = 1'b0;
        ready          = 1'b0;
        move_en        = 1'b0;
        move_up        = 1'b0;

        case (operation)
            OP_TICK:
            begin
                // Elapsed counters count up and stick at their maximum.
                if (run_el_reg != {INTERVAL_BITS{1'b1}})
                    run_el_next = run_el_reg + 1'b1;
                if (home_el_reg != HOME_ELAPSED_MAX)
                    home_el_next = home_el_reg + 16'd1;
                if (settle_el_reg != SETTLE_ELAPSED_MAX)
                    settle_el_next = settle_el_reg + 32'd1;

                // Run pulse once the interval has elapsed.
                if (mode_reg == MODE_RUN && run_ivl_reg != '0 && run_el_next >= run_ivl_reg)
                begin
                    run_el_next  = '0;
                    dir_pin_next = run_dir_reg;
                    pulse        = 1'b1;
                    move_en      = 1'b1;
                    move_up      = run_dir_reg;
                end

                // Homing steps toward zero, then enters settling.
                if (mode_reg == MODE_HOME)
                begin
                    if (step_count_reg == '0)
                    begin
                        mode_next      = MODE_SETTLE;
                        settle_el_next = '0;
                        reached        = 1'b1;
                    end
                    else if (home_el_next >= cfg.home_step_interval)
                    begin
                        home_el_next = '0;
                        dir_pin_next = step_count_reg[POSITION_BITS-1];
                        pulse        = 1'b1;
                        move_en      = 1'b1;
                        move_up      = step_count_reg[POSITION_BITS-1];
                    end
                end

                // Settling ends after the settle time.
                if (mode_next == MODE_SETTLE && settle_el_next >= cfg.settle_time)
                begin
                    mode_next = MODE_RUN;
                    ready     = 1'b1;
                end
            end
            OP_START:
                mode_next = MODE_RUN;
            OP_PAUSE:
            begin
                mode_next    = MODE_IDLE;
                run_ivl_next = '0;
            end
            OP_HOME:
            begin
                mode_next    = MODE_HOME;
                run_ivl_next = '0;
            end
            OP_SPEED:
            begin
                run_ivl_next = step_interval;
                if (step_interval != '0)
                begin
                    run_dir_next = direction;
                    if (mode_reg != MODE_HOME)
                        dir_pin_next = direction;
                end
            end
            default: ;
        endcase

        // Position moves by one step and wraps.
        step_count_next = step_count_reg;
        if (move_en)
        begin
            if (move_up)
                step_count_next = step_count_reg + 1'b1;
            else
                step_count_next = step_count_reg - 1'b1;
        end
    end

    // State registers, updated as each item passes to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            step_count_reg <= '0;
            run_ivl_reg    <= '0;
            run_dir_reg    <= 1'b0;
            dir_pin_reg    <= 1'b0;
            run_el_reg     <= '0;
            home_el_reg    <= '0;
            settle_el_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            step_count_reg <= step_count_next;
            run_ivl_reg    <= run_ivl_next;
            run_dir_reg    <= run_dir_next;
            dir_pin_reg    <= dir_pin_next;
            run_el_reg     <= run_el_next;
            home_el_reg    <= home_el_next;
            settle_el_reg  <= settle_el_next;
        end
    end

    assign flags.step_pulse   = pulse;
    assign flags.dir_level    = dir_pin_next;
    assign flags.mode         = mode_next;
    assign flags.reached_zero = reached;
    assign flags.ready_res    = ready;
    assign position           = step_count_next;

endmodule

`default_nettype wire

// ----- rtl/stepper_motion_sequencer_top.sv -----
// Top level of the stepper motion sequencer: stream channels, pipeline registers, config.
//
// Each request on the input stream is a one-microsecond tick or a command
// (start, pause, home, set speed), selected by the operation code on tuser.
// Every request gives exactly one result on the output stream: step pulse,
// direction level, signed position, mode and the zero-reached and ready flags.
// A request is held in an input register, then evaluated against the motion
// state by one pass of compare and increment logic and written to the result
// register. One request is taken every cycle while the receiver does not
// stall. When the receiver stalls, the result register holds; the input
// register still takes one more request, after which the input tready drops
// until the result is taken. The two registers home_step_interval (address
// 0) and settle_time (address 4) are written over the APB-style port; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Reset empties both pipeline registers, sets the mode to
// idle, clears position, speed and counters and loads the register defaults.
`default_nettype none

module stepper_motion_sequencer_top
    import smseq_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int INTERVAL_BITS = 24,
    localparam int IN_W  = ((INTERVAL_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((POSITION_BITS + 6 + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input stream.
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // step_interval, direction, zero fill
    input  wire logic [2:0]       s_axis_tuser,  // operation
    // Output stream.
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // step_pulse, dir_level, position, mode,
                                                 // reached_zero, ready_res, zero fill
    // Configuration port.
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int PAD_W = OUT_W - POSITION_BITS - 6;

    cfg_t cfg;

    logic                     in_valid_reg;
    logic [2:0]               in_op_reg;
    logic [INTERVAL_BITS-1:0] in_ivl_reg;
    logic                     in_dir_reg;

    logic                     out_valid_reg;
    flags_t                   out_flags_reg;
    logic [POSITION_BITS-1:0] out_pos_reg;

    flags_t                   core_flags;
    logic [POSITION_BITS-1:0] core_pos;
    logic                     advance;
    logic                     in_take;

    // Handshake control of the two pipeline registers.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    smseq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smseq_core #(
        .POSITION_BITS (POSITION_BITS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .advance       (advance),
        .operation     (in_op_reg),
        .step_interval (in_ivl_reg),
        .direction     (in_dir_reg),
        .flags         (core_flags),
        .position      (core_pos)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg  <= s_axis_tuser;
            in_ivl_reg <= s_axis_tdata[INTERVAL_BITS-1:0];
            in_dir_reg <= s_axis_tdata[INTERVAL_BITS];
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg <= core_flags;
            out_pos_reg   <= core_pos;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}},
                            out_flags_reg.ready_res,
                            out_flags_reg.reached_zero,
                            out_flags_reg.mode,
                            out_pos_reg,
                            out_flags_reg.dir_level,
                            out_flags_reg.step_pulse};

    // A resumed run is reported only in running mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flags_reg.ready_res) |-> (out_flags_reg.mode == MODE_RUN))
        else $error("ready_res reported outside running mode");

    // Reaching zero leaves the sequencer settling or already running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flags_reg.reached_zero) |->
        (out_flags_reg.mode == MODE_SETTLE || out_flags_reg.mode == MODE_RUN))
        else $error("reached_zero reported in a wrong mode");

    // A pulse and reaching zero never fall on the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_flags_reg.step_pulse && out_flags_reg.reached_zero))
        else $error("step pulse issued on the zero-reached item");

    // A request held in the input register is not dropped while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled request lost from the input register");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the stepper motion sequencer with a built-in motion predictor.
`timescale 1ns / 1ps

module testbench;
    import smseq_pkg::*;

    // One result of the sequencer, unpacked from the output tdata.
    typedef struct packed {
        logic               step_pulse;
        logic               dir_level;
        logic signed [31:0] position;
        mode_t              mode;
        logic               reached_zero;
        logic               ready_res;
    } step_result_t;

    // One row of the directed stimulus; typed rows carry their expected result.
    typedef struct packed {
        logic [2:0]   op;
        logic [23:0]  interval;
        logic         dir;
        logic         typed;
        step_result_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 120;
    localparam int FINAL_TICKS   = 40;
    localparam logic [23:0] INTERVAL_MAX = 24'hFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // step_interval [23:0], direction [24], zero fill
    logic [2:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;   // step_pulse [0], dir_level [1], position [33:2],
                                 // mode [35:34], reached_zero [36], ready_res [37], zero fill
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stepper_motion_sequencer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predicted motion state and register copies.
    mode_t       motion_mode;
    logic [31:0] step_pos;
    logic [23:0] run_ivl;
    logic        run_direction;
    logic        dir_pin_level;
    logic [23:0] run_ticks;
    logic [15:0] home_ticks;
    logic [31:0] settle_ticks;
    logic [15:0] home_ivl_setting;
    logic [31:0] settle_setting;

    step_result_t expected_results[$];
    int  mismatch_count = 0;
    int  sent_count = 0;
    bit  gap_enable = 1'b1;
    bit  stall_enable = 1'b1;
    int  stall_left = 0;

    // Directed stimulus: reset state, unused codes, speed extremes, homing corner cases.
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{OP_TICK,  24'd0,        1'b0, 1'b1, '{1'b0, 1'b0, 32'sd0, MODE_IDLE, 1'b0, 1'b0}},
        '{3'd5,     INTERVAL_MAX, 1'b1, 1'b1, '{1'b0, 1'b0, 32'sd0, MODE_IDLE, 1'b0, 1'b0}},
        '{3'd7,     24'h5A5A5A,   1'b1, 1'b1, '{1'b0, 1'b0, 32'sd0, MODE_IDLE, 1'b0, 1'b0}},
        '{OP_SPEED, 24'd0,        1'b1, 1'b1, '{1'b0, 1'b0, 32'sd0, MODE_IDLE, 1'b0, 1'b0}},
        '{OP_START, 24'd0,        1'b0, 1'b1, '{1'b0, 1'b0, 32'sd0, MODE_RUN,  1'b0, 1'b0}},
        '{OP_TICK,  24'd0,        1'b0, 1'b1, '{1'b0, 1'b0, 32'sd0, MODE_RUN,  1'b0, 1'b0}},
        '{OP_SPEED, 24'd1,        1'b1, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_SPEED, INTERVAL_MAX, 1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_SPEED, 24'd2,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_SPEED, 24'd1,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_PAUSE, 24'd0,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_HOME,  24'd0,        1'b0, 1'b0, '0},
        '{OP_SPEED, 24'd5,        1'b1, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_HOME,  24'd0,        1'b0, 1'b0, '0},
        '{OP_TICK,  24'd0,        1'b0, 1'b0, '0},
        '{OP_START, 24'd0,        1'b0, 1'b0, '0}
    };

    // Register settings for the random phases, extremes among them.
    logic [15:0] phase_home_ivl [0:RANDOM_PHASES-1] =
        '{16'd1, 16'd0, 16'd3, 16'd2, 16'd7, 16'd65535, 16'd4, 16'd2500};
    logic [31:0] phase_settle [0:RANDOM_PHASES-1] =
        '{32'd0, 32'd2, 32'd10, 32'd1, 32'd25, 32'hFFFF_FFFF, 32'd60, 32'd4000000};

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Clear the predicted state as reset does.
    function automatic void reset_motion_state();
        motion_mode      = MODE_IDLE;
        step_pos         = '0;
        run_ivl          = '0;
        run_direction    = 1'b0;
        dir_pin_level    = 1'b0;
        run_ticks        = '0;
        home_ticks       = '0;
        settle_ticks     = '0;
        home_ivl_setting = HOME_IVL_RESET;
        settle_setting   = SETTLE_RESET;
    endfunction

    // Advance the predicted motion state by one request and return its result.
    function automatic step_result_t advance_motion(input logic [2:0] op,
                                                    input logic [23:0] ivl,
                                                    input logic dir);
        step_result_t res;
        logic         up;
        res = '0;
        case (op)
            OP_TICK:
            begin
                if (run_ticks != INTERVAL_MAX)
                    run_ticks = run_ticks + 1'b1;
                if (home_ticks != HOME_ELAPSED_MAX)
                    home_ticks = home_ticks + 1'b1;
                if (settle_ticks != SETTLE_ELAPSED_MAX)
                    settle_ticks = settle_ticks + 1'b1;

                // Run stage.
                if (motion_mode == MODE_RUN && run_ivl != 0 && run_ticks >= run_ivl)
                begin
                    run_ticks      = '0;
                    dir_pin_level  = run_direction;
                    res.step_pulse = 1'b1;
                    step_pos       = run_direction ? step_pos + 1 : step_pos - 1;
                end

                // Homing stage: step toward zero, or start settling once there.
                if (motion_mode == MODE_HOME)
                begin
                    if (step_pos == 0)
                    begin
                        motion_mode      = MODE_SETTLE;
                        settle_ticks     = '0;
                        res.reached_zero = 1'b1;
                    end
                    else if (home_ticks >= home_ivl_setting)
                    begin
                        up             = step_pos[31];
                        home_ticks     = '0;
                        dir_pin_level  = up;
                        res.step_pulse = 1'b1;
                        step_pos       = up ? step_pos + 1 : step_pos - 1;
                    end
                end

                // Settling stage.
                if (motion_mode == MODE_SETTLE && settle_ticks >= settle_setting)
                begin
                    motion_mode   = MODE_RUN;
                    res.ready_res = 1'b1;
                end
            end
            OP_START:
                motion_mode = MODE_RUN;
            OP_PAUSE:
            begin
                motion_mode = MODE_IDLE;
                run_ivl     = '0;
            end
            OP_HOME:
            begin
                motion_mode = MODE_HOME;
                run_ivl     = '0;
            end
            OP_SPEED:
            begin
                run_ivl = ivl;
                if (ivl != 0)
                begin
                    run_direction = dir;
                    if (motion_mode != MODE_HOME)
                        dir_pin_level = dir;
                end
            end
            default:
                ;
        endcase
        res.dir_level = dir_pin_level;
        res.position  = step_pos;
        res.mode      = motion_mode;
        return res;
    endfunction

    // Send one request, with an optional random gap first; predict it on acceptance.
    task automatic send_request(input logic [2:0] op, input logic [23:0] ivl,
                                input logic dir, input bit use_typed = 1'b0,
                                input step_result_t typed_want = '0);
        step_result_t predicted;
        if (gap_enable && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, dir, ivl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = advance_motion(op, ivl, dir);
        expected_results.push_back(use_typed ? typed_want : predicted);
        sent_count++;
        @(negedge clk);
    endtask

    // Any operation code, including the unused ones, with random fields.
    task automatic send_noise();
        send_request(3'($urandom_range(0, 7)), 24'($urandom), 1'($urandom));
    endtask

    // Ticks with random don't-care fields, sprinkled with noise.
    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_request(OP_TICK, 24'($urandom), 1'($urandom));
        end
    endtask

    // Run intervals: mostly short, sometimes zero, the maximum or any value.
    function automatic logic [23:0] pick_interval();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 24'd0;
        else if (sel == 1)
            return INTERVAL_MAX;
        else if (sel == 2)
            return 24'($urandom);
        return 24'($urandom_range(1, 6));
    endfunction

    // One well-formed motion: set speed, start, run, then pause, retune or home.
    task automatic run_motion_sequence();
        longint distance;
        longint needed;
        send_request(OP_SPEED, pick_interval(), 1'($urandom));
        send_request(OP_START, 24'($urandom), 1'($urandom));
        send_ticks($urandom_range(4, 30));
        case ($urandom_range(0, 3))
            0:
            begin
                send_request(OP_PAUSE, 24'($urandom), 1'($urandom));
                send_ticks($urandom_range(2, 6));
            end
            1:
            begin
                send_request(OP_SPEED, pick_interval(), 1'($urandom));
                send_ticks($urandom_range(4, 20));
            end
            default:
            begin
                send_request(OP_HOME, 24'($urandom), 1'($urandom));
                if ($urandom_range(0, 3) == 0)
                    send_request(OP_SPEED, pick_interval(), 1'($urandom));
                distance = step_pos[31] ? -longint'($signed(step_pos))
                                        : longint'(step_pos);
                needed = distance * (longint'(home_ivl_setting) + 1)
                         + longint'(settle_setting) + 3;
                send_ticks((needed > 60) ? 60 : int'(needed));
            end
        endcase
    endtask

    // Write one register over the configuration port.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Let the block drain, then load both registers.
    task automatic configure_when_idle(input logic [15:0] home_ivl, input logic [31:0] settle);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        write_register({REG_HOME_IVL, 2'b00}, {16'd0, home_ivl});
        home_ivl_setting = home_ivl;
        write_register({REG_SETTLE, 2'b00}, settle);
        settle_setting = settle;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endtask

    // Receiver side: random stall bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (stall_enable && $urandom_range(0, 4) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        step_result_t got;
        step_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.step_pulse   = m_axis_tdata[0];
            got.dir_level    = m_axis_tdata[1];
            got.position     = m_axis_tdata[33:2];
            got.mode         = m_axis_tdata[35:34];
            got.reached_zero = m_axis_tdata[36];
            got.ready_res    = m_axis_tdata[37];
            if (expected_results.size() == 0)
                note_mismatch("unrequested result", 32'd0, m_axis_tdata[31:0]);
            else
            begin
                want = expected_results.pop_front();
                if (got.step_pulse != want.step_pulse)
                    note_mismatch("step_pulse", want.step_pulse, got.step_pulse);
                if (got.dir_level != want.dir_level)
                    note_mismatch("dir_level", want.dir_level, got.dir_level);
                if (got.position != want.position)
                    note_mismatch("position", want.position, got.position);
                if (got.mode != want.mode)
                    note_mismatch("mode", want.mode, got.mode);
                if (got.reached_zero != want.reached_zero)
                    note_mismatch("reached_zero", want.reached_zero, got.reached_zero);
                if (got.ready_res != want.ready_res)
                    note_mismatch("ready_res", want.ready_res, got.ready_res);
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        reset_motion_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows; homing corner cases run with a fast home and no settle wait.
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (row == 17)
                configure_when_idle(16'd1, 32'd0);
            send_request(directed_rows[row].op, directed_rows[row].interval,
                         directed_rows[row].dir, directed_rows[row].typed,
                         directed_rows[row].want);
        end

        // Random motion under several register settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 6)
                configure_when_idle(16'($urandom_range(1, 9)), 32'($urandom_range(0, 40)));
            else
                configure_when_idle(phase_home_ivl[phase], phase_settle[phase]);
            while (sent_count < DIRECTED_ROWS + (phase + 1) * PHASE_ITEMS)
                run_motion_sequence();
        end

        // Final stretch without idling: step off zero, pause for a while,
        // then home at the longest interval.
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
        configure_when_idle(16'hFFFF, 32'hFFFF_FFFF);
        send_request(OP_SPEED, 24'd1, 1'b1);
        send_request(OP_START, 24'd0, 1'b0);
        do
            send_request(OP_TICK, 24'($urandom), 1'($urandom));
        while (step_pos == 0);
        send_request(OP_PAUSE, 24'd0, 1'b0);
        for (int i = 0; i < FINAL_TICKS; i++)
            send_request(OP_TICK, 24'($urandom), 1'($urandom));
        send_request(OP_HOME, 24'd0, 1'b0);
        send_ticks(3);

        // Drain and report.
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
